/* hdl/olsr_pkg.sv */
// ----------------------------------------------------------------------------
// olsr_pkg - shared types and constants of the occupancy level stay reporter
// Register indexes, level codes, sequencer states and the command and
// status words exchanged with the iterative multiply/divide unit.
// ----------------------------------------------------------------------------
`default_nettype none

package olsr_pkg;

  // fixed arithmetic widths
  localparam int unsigned OCC_BITS         = 64;
  localparam int unsigned AVG_BITS         = 32;
  localparam int unsigned MS_PER_SEC       = 1000;
  localparam int unsigned MS_BITS          = 10;
  localparam int unsigned INTERVAL_BITS    = 16;
  localparam int unsigned INTERVAL_MS_BITS = INTERVAL_BITS + MS_BITS;
  localparam int unsigned INTERVAL_MS_RST  = 60 * MS_PER_SEC;
  localparam int unsigned THR_BITS         = 8;
  localparam int unsigned LEVEL_BITS       = 2;
  localparam int unsigned OUT_COUNT_BITS   = 8;
  localparam int unsigned COUNT_EXT_BITS   = 16;

  // iteration counter of the shared unit
  localparam int unsigned DIV_STEPS = OCC_BITS;
  localparam int unsigned STEP_BITS = 7;

  // configuration port
  localparam int unsigned CFG_IDX_BITS  = 3;
  localparam int unsigned CFG_DATA_BITS = 16;

  localparam logic [CFG_IDX_BITS-1:0] REG_BLOCK_ENABLE = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_LEVEL_MASK   = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_NORMAL_THR   = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_MEDIUM_THR   = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_SEVERE_THR   = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_INTERVAL_SEC = 3'd5;

  // density level codes
  localparam logic [LEVEL_BITS-1:0] LVL_NONE   = 2'd0;
  localparam logic [LEVEL_BITS-1:0] LVL_NORMAL = 2'd1;
  localparam logic [LEVEL_BITS-1:0] LVL_MEDIUM = 2'd2;
  localparam logic [LEVEL_BITS-1:0] LVL_SEVERE = 2'd3;

  // level enable mask bits
  localparam int unsigned MASK_NORMAL = 0;
  localparam int unsigned MASK_MEDIUM = 1;
  localparam int unsigned MASK_SEVERE = 2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ACC0,
    S_MUL,
    S_ACC,
    S_CHK,
    S_DIV,
    S_OUT
  } olsr_state_e;

  typedef enum logic {
    OP_MUL,
    OP_DIV
  } olsr_op_e;

  typedef struct packed {
    logic     start;
    olsr_op_e op;
  } olsr_req_t;

  typedef struct packed {
    logic                done;
    logic [OCC_BITS-1:0] res;
  } olsr_stat_t;

endpackage

`default_nettype wire

/* hdl/olsr_if.sv */
// ----------------------------------------------------------------------------
// olsr_if - valid/ready channels of the occupancy level stay reporter
// Sample input, result output and configuration write channels.
// ----------------------------------------------------------------------------
`default_nettype none

interface olsr_in_if #(
  parameter int unsigned TIME_BITS      = 48,
  parameter int unsigned MAX_COUNT_BITS = 8
);
  logic                      valid;
  logic                      ready;
  logic [TIME_BITS-1:0]      timestamp_ms;
  logic [MAX_COUNT_BITS-1:0] people_count;

  modport source (output valid, output timestamp_ms, output people_count, input ready);
  modport sink   (input valid, input timestamp_ms, input people_count, output ready);
endinterface

interface olsr_out_if;
  import olsr_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [LEVEL_BITS-1:0]     density_level;
  logic [OUT_COUNT_BITS-1:0] current_count;
  logic                      report_valid;
  logic [AVG_BITS-1:0]       report_number;
  logic [AVG_BITS-1:0]       stay_avg_sec;

  modport source (output valid, output density_level, output current_count,
                  output report_valid, output report_number, output stay_avg_sec,
                  input ready);
  modport sink   (input valid, input density_level, input current_count,
                  input report_valid, input report_number, input stay_avg_sec,
                  output ready);
endinterface

interface olsr_cfg_if;
  import olsr_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [CFG_IDX_BITS-1:0]  index;
  logic [CFG_DATA_BITS-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* hdl/olsr_muldiv.sv */
// ----------------------------------------------------------------------------
// olsr_muldiv - iterative shift-add multiplier and restoring divider
// One adder serves both operations, one bit per cycle. Multiply gives
// a * b saturated to 64 bits; divide gives the 64-bit quotient a / b.
// ----------------------------------------------------------------------------
`default_nettype none

module olsr_muldiv #(
  parameter int unsigned TIME_BITS      = 48,
  parameter int unsigned MAX_COUNT_BITS = 8
) (
  input  wire                                          clk_i,
  input  wire                                          rst_ni,
  input  olsr_pkg::olsr_req_t                          req_i,
  input  wire [olsr_pkg::OCC_BITS-1:0]                 a_i,
  input  wire [MAX_COUNT_BITS+olsr_pkg::MS_BITS-1:0]   b_i,
  output olsr_pkg::olsr_stat_t                         stat_o
);
  import olsr_pkg::*;

  localparam int unsigned PW = TIME_BITS + MAX_COUNT_BITS;

  logic                 busy_q;
  logic                 done_q;
  olsr_op_e             op_q;
  logic [STEP_BITS-1:0] steps_q;
  logic [PW-1:0]        acc_q, acc_d;
  logic [PW-1:0]        opa_q, opa_d;
  logic [OCC_BITS-1:0]  opb_q, opb_d;

  logic [PW-1:0]        add_x, add_y;
  logic                 add_c;
  logic [PW:0]          sum;
  logic [PW-1:0]        rsh;
  logic                 over;

  // shared adder: accumulate partial product or trial subtract
  assign rsh = {acc_q[PW-2:0], opb_q[OCC_BITS-1]};

  always_comb begin
    if (op_q == OP_MUL) begin
      add_x = acc_q;
      add_y = opb_q[0] ? opa_q : '0;
      add_c = 1'b0;
    end else begin
      add_x = rsh;
      add_y = ~opa_q;
      add_c = 1'b1;
    end
    sum = {1'b0, add_x} + {1'b0, add_y} + (PW+1)'(add_c);
  end

  // next operand values for one step
  always_comb begin
    if (op_q == OP_MUL) begin
      acc_d = sum[PW-1:0];
      opa_d = opa_q << 1;
      opb_d = opb_q >> 1;
    end else begin
      acc_d = sum[PW] ? sum[PW-1:0] : rsh;
      opa_d = opa_q;
      opb_d = {opb_q[OCC_BITS-2:0], sum[PW]};
    end
  end

  // step counter and done pulse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      op_q    <= OP_MUL;
      steps_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q  <= 1'b1;
        op_q    <= req_i.op;
        steps_q <= (req_i.op == OP_MUL) ? STEP_BITS'(MAX_COUNT_BITS) : STEP_BITS'(DIV_STEPS);
      end else if (busy_q) begin
        steps_q <= steps_q - STEP_BITS'(1);
        if (steps_q == STEP_BITS'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // operand registers
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      acc_q <= '0;
      if (req_i.op == OP_MUL) begin
        opa_q <= PW'(a_i);
        opb_q <= OCC_BITS'(b_i);
      end else begin
        opa_q <= PW'(b_i);
        opb_q <= a_i;
      end
    end else if (busy_q) begin
      acc_q <= acc_d;
      opa_q <= opa_d;
      opb_q <= opb_d;
    end
  end

  // product saturates to 64 bits; quotient is taken as is
  assign over = (acc_q >> OCC_BITS) != '0;

  assign stat_o.done = done_q;
  assign stat_o.res  = (op_q == OP_MUL) ? (over ? '1 : OCC_BITS'(acc_q)) : opb_q;

endmodule

`default_nettype wire

/* hdl/occupancy_level_stay_reporter.sv */
// ----------------------------------------------------------------------------
// occupancy_level_stay_reporter - density level and periodic stay report
// Classifies each frame's people count and integrates occupancy over time,
// emitting a report with the average stay every report interval.
// ----------------------------------------------------------------------------
// Usage:
//   in_i  : one word per frame (timestamp_ms, people_count).
//   out_o : one word per accepted frame while block_enable is set: density
//           level, echoed count and, when a report falls due, its sequence
//           number and average stay in seconds. Disabled frames are dropped.
//   cfg_i : register writes (index, data), always ready; write only while idle.
// Sequence: a sample is taken only in the idle state. It passes S_ACC0,
//   the multiply in S_MUL and S_ACC (skipped for a first or backwards
//   sample), then S_CHK, the divide in S_DIV when a report falls due with
//   a nonzero peak and integral, and S_OUT, which loads the result word.
//   The next sample is taken in the cycle after the load.
// Output: the result word sits in an output register, so the next sample is
//   taken while the receiver stalls; that sample's result waits until the
//   register is free.
// Reset: all state and accumulators clear, the block is disabled and the
//   report interval is 60 s. Writing 0 to block_enable clears the sample,
//   integral, peak and report state too.
`default_nettype none

module occupancy_level_stay_reporter #(
  parameter int unsigned MAX_COUNT_BITS = 8,
  parameter int unsigned TIME_BITS      = 48
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  olsr_in_if.sink    in_i,
  olsr_out_if.source out_o,
  olsr_cfg_if.sink   cfg_i
);
  import olsr_pkg::*;

  localparam int unsigned DW = MAX_COUNT_BITS + MS_BITS;

  // configuration registers
  logic                        en_q;
  logic [2:0]                  mask_q;
  logic [THR_BITS-1:0]         nrm_thr_q, med_thr_q, sev_thr_q;
  logic [INTERVAL_MS_BITS-1:0] intv_ms_q;

  // block state
  logic                      smp_started_q;
  logic [TIME_BITS-1:0]      last_time_q;
  logic [MAX_COUNT_BITS-1:0] last_cnt_q;
  logic [MAX_COUNT_BITS-1:0] peak_q;
  logic [OCC_BITS-1:0]       occ_q;
  logic                      rpt_started_q;
  logic [TIME_BITS-1:0]      rpt_time_q;
  logic [AVG_BITS-1:0]       seq_q;

  // current sample and report work
  logic [TIME_BITS-1:0]      now_q;
  logic [MAX_COUNT_BITS-1:0] cnt_q;
  logic                      rep_q;
  logic [AVG_BITS-1:0]       avg_q;

  // output register
  logic                      out_valid_q;
  logic [LEVEL_BITS-1:0]     out_level_q;
  logic [OUT_COUNT_BITS-1:0] out_count_q;
  logic                      out_rep_q;
  logic [AVG_BITS-1:0]       out_num_q;
  logic [AVG_BITS-1:0]       out_avg_q;

  olsr_state_e state_q, state_d;
  olsr_req_t   mreq;
  olsr_stat_t  mstat;
  logic [OCC_BITS-1:0] mul_a;
  logic [DW-1:0]       mul_b;

  logic                      in_fire, out_fire, cfg_fire, out_load;
  logic                      smp_behind, rpt_behind, rep_fire;
  logic [TIME_BITS-1:0]      rpt_elapsed;
  logic [OCC_BITS:0]         occ_sum;
  logic [OCC_BITS-1:0]       occ_sat;
  logic [COUNT_EXT_BITS-1:0] cnt_ext;
  logic [LEVEL_BITS-1:0]     level;

  assign in_fire  = in_i.valid && in_i.ready;
  assign out_fire = out_o.valid && out_o.ready;
  assign cfg_fire = cfg_i.valid && cfg_i.ready;

  assign in_i.ready  = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;

  // time compares
  assign smp_behind  = now_q < last_time_q;
  assign rpt_behind  = now_q < rpt_time_q;
  assign rpt_elapsed = now_q - rpt_time_q;
  assign rep_fire    = rpt_started_q && !rpt_behind &&
                       (rpt_elapsed >= TIME_BITS'(intv_ms_q));

  // saturating integral update
  assign occ_sum = {1'b0, occ_q} + {1'b0, mstat.res};
  assign occ_sat = occ_sum[OCC_BITS] ? '1 : occ_sum[OCC_BITS-1:0];

  // density classification, severe first
  assign cnt_ext = COUNT_EXT_BITS'(cnt_q);

  always_comb begin
    if (mask_q[MASK_SEVERE] && cnt_ext >= COUNT_EXT_BITS'(sev_thr_q)) begin
      level = LVL_SEVERE;
    end else if (mask_q[MASK_MEDIUM] && cnt_ext >= COUNT_EXT_BITS'(med_thr_q)) begin
      level = LVL_MEDIUM;
    end else if (mask_q[MASK_NORMAL] && cnt_ext >= COUNT_EXT_BITS'(nrm_thr_q)) begin
      level = LVL_NORMAL;
    end else begin
      level = LVL_NONE;
    end
  end

  // operands for the shared unit
  always_comb begin
    if (state_q == S_ACC0) begin
      mul_a = OCC_BITS'(now_q - last_time_q);
      mul_b = DW'(last_cnt_q);
    end else begin
      mul_a = occ_q;
      mul_b = DW'(peak_q) * DW'(MS_PER_SEC);
    end
  end

  olsr_muldiv #(
    .TIME_BITS      (TIME_BITS),
    .MAX_COUNT_BITS (MAX_COUNT_BITS)
  ) u_muldiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mreq),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .stat_o (mstat)
  );

  // sequencer state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // sequencer next state and unit commands
  always_comb begin
    state_d    = state_q;
    mreq.start = 1'b0;
    mreq.op    = OP_MUL;
    out_load   = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire && en_q) begin
          state_d = S_ACC0;
        end
      end
      S_ACC0: begin
        if (smp_started_q && !smp_behind) begin
          mreq.start = 1'b1;
          mreq.op    = OP_MUL;
          state_d    = S_MUL;
        end else begin
          state_d = S_CHK;
        end
      end
      S_MUL: begin
        if (mstat.done) begin
          state_d = S_ACC;
        end
      end
      S_ACC: begin
        state_d = S_CHK;
      end
      S_CHK: begin
        if (rep_fire && peak_q != '0 && occ_q != '0) begin
          mreq.start = 1'b1;
          mreq.op    = OP_DIV;
          state_d    = S_DIV;
        end else begin
          state_d = S_OUT;
        end
      end
      S_DIV: begin
        if (mstat.done) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_q || out_o.ready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // configuration, state and datapath registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q          <= 1'b0;
      mask_q        <= '0;
      nrm_thr_q     <= '0;
      med_thr_q     <= '0;
      sev_thr_q     <= '0;
      intv_ms_q     <= INTERVAL_MS_BITS'(INTERVAL_MS_RST);
      smp_started_q <= 1'b0;
      last_time_q   <= '0;
      last_cnt_q    <= '0;
      peak_q        <= '0;
      occ_q         <= '0;
      rpt_started_q <= 1'b0;
      rpt_time_q    <= '0;
      seq_q         <= '0;
      now_q         <= '0;
      cnt_q         <= '0;
      rep_q         <= 1'b0;
      avg_q         <= '0;
      out_valid_q   <= 1'b0;
      out_level_q   <= '0;
      out_count_q   <= '0;
      out_rep_q     <= 1'b0;
      out_num_q     <= '0;
      out_avg_q     <= '0;
    end else begin
      // register writes
      if (cfg_fire) begin
        unique case (cfg_i.index)
          REG_BLOCK_ENABLE: begin
            en_q <= cfg_i.data[0];
            if (!cfg_i.data[0]) begin
              smp_started_q <= 1'b0;
              last_time_q   <= '0;
              last_cnt_q    <= '0;
              peak_q        <= '0;
              occ_q         <= '0;
              rpt_started_q <= 1'b0;
              rpt_time_q    <= '0;
              seq_q         <= '0;
            end
          end
          REG_LEVEL_MASK: mask_q    <= cfg_i.data[2:0];
          REG_NORMAL_THR: nrm_thr_q <= cfg_i.data[THR_BITS-1:0];
          REG_MEDIUM_THR: med_thr_q <= cfg_i.data[THR_BITS-1:0];
          REG_SEVERE_THR: sev_thr_q <= cfg_i.data[THR_BITS-1:0];
          REG_INTERVAL_SEC: begin
            if (cfg_i.data[INTERVAL_BITS-1:0] != '0) begin
              intv_ms_q <= INTERVAL_MS_BITS'(cfg_i.data[INTERVAL_BITS-1:0]) *
                           INTERVAL_MS_BITS'(MS_PER_SEC);
            end
          end
          default: ;
        endcase
      end

      // sample capture
      if (in_fire) begin
        now_q <= in_i.timestamp_ms;
        cnt_q <= in_i.people_count;
      end

      // first sample or time going backwards
      if (state_q == S_ACC0) begin
        if (!smp_started_q) begin
          smp_started_q <= 1'b1;
          last_time_q   <= now_q;
          last_cnt_q    <= cnt_q;
          peak_q        <= cnt_q;
        end else if (smp_behind) begin
          occ_q       <= '0;
          last_time_q <= now_q;
          last_cnt_q  <= cnt_q;
          peak_q      <= cnt_q;
        end
      end

      // integral and peak update
      if (state_q == S_ACC) begin
        occ_q       <= occ_sat;
        last_time_q <= now_q;
        last_cnt_q  <= cnt_q;
        if (cnt_q > peak_q) begin
          peak_q <= cnt_q;
        end
      end

      // report check; divider already holds the old integral and peak
      if (state_q == S_CHK) begin
        rep_q <= 1'b0;
        avg_q <= '0;
        if (!rpt_started_q) begin
          rpt_started_q <= 1'b1;
          rpt_time_q    <= now_q;
        end else if (rep_fire) begin
          rpt_time_q <= now_q;
          seq_q      <= seq_q + AVG_BITS'(1);
          rep_q      <= 1'b1;
          occ_q      <= '0;
          last_cnt_q <= cnt_q;
          peak_q     <= cnt_q;
        end
      end

      // average stay, saturated to 32 bits
      if (state_q == S_DIV && mstat.done) begin
        avg_q <= (mstat.res[OCC_BITS-1:AVG_BITS] != '0) ? '1 : mstat.res[AVG_BITS-1:0];
      end

      // output register
      if (out_load) begin
        out_valid_q <= 1'b1;
        out_level_q <= level;
        out_count_q <= cnt_ext[OUT_COUNT_BITS-1:0];
        out_rep_q   <= rep_q;
        out_num_q   <= rep_q ? seq_q : '0;
        out_avg_q   <= rep_q ? avg_q : '0;
      end else if (out_fire) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.density_level = out_level_q;
  assign out_o.current_count = out_count_q;
  assign out_o.report_valid  = out_rep_q;
  assign out_o.report_number = out_num_q;
  assign out_o.stay_avg_sec  = out_avg_q;

endmodule

`default_nettype wire
